### hw/rtl/bffa_pkg.sv
// Shared constants, codes and controller/datapath interface types of the block allocator.
package bffa_pkg;

	localparam int MAX_BLOCKS   = 1024;
	localparam int HEADER_BYTES = 4;

	localparam int BLK_W  = $clog2(MAX_BLOCKS);
	localparam int CNT_W  = BLK_W + 1;
	localparam int IDX_W  = (CNT_W > 11) ? CNT_W : 11;
	localparam int ADDR_W = 22;
	localparam int SIZE_W = 23;
	localparam int SEC_W  = 13;
	localparam int DIV_W  = 24;
	localparam int PRD_W  = IDX_W + SEC_W + 1;

	localparam logic [ADDR_W-1:0] ADDR_MAX = {ADDR_W{1'b1}};

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_NULL    = 2'd2;

	localparam logic [1:0] REG_SECTOR   = 2'd0;
	localparam logic [1:0] REG_TOTAL    = 2'd1;
	localparam logic [1:0] REG_RESERVED = 2'd2;

	localparam logic [1:0] DSEL_NEED  = 2'd0;
	localparam logic [1:0] DSEL_FIRST = 2'd1;
	localparam logic [1:0] DSEL_RUN   = 2'd2;

	typedef struct packed {
		logic       clr_step;
		logic       load_req;
		logic       div_go;
		logic [1:0] div_sel;
		logic       scan_init;
		logic       scan_run;
		logic       mark_run;
		logic       first_load;
		logic       size_load;
		logic       free_set;
		logic       free_run;
		logic       free_fin;
		logic       fire;
		logic       grant;
		logic [1:0] code;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic div_done;
		logic hit;
		logic fail;
		logic mark_last;
		logic free_more;
		logic rel_zero;
		logic rel_small;
	} sts_t;

endpackage

### hw/rtl/bffa_divider.sv
// Restoring divider that produces one quotient bit per cycle.
module bffa_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [bffa_pkg::DIV_W-1:0] dividend,
	input  logic [bffa_pkg::SEC_W-1:0] divisor,
	output logic                       done,
	output logic [bffa_pkg::DIV_W-1:0] quotient
);
	import bffa_pkg::*;

	localparam int CW = $clog2(DIV_W + 1);

	logic [SEC_W-1:0] rem_q;
	logic [SEC_W-1:0] d_q;
	logic [DIV_W-1:0] quo_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             done_q;
	logic [SEC_W:0]   trial;
	logic [SEC_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign ge    = trial >= {1'b0, d_q};
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIV_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			d_q   <= divisor;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= ge ? diff[SEC_W-1:0] : trial[SEC_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

### hw/rtl/bffa_datapath.sv
// Datapath: configuration, bitmap and size memories, scan, mark and clear logic.
module bffa_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bffa_pkg::cmd_t              cmd,
	output bffa_pkg::sts_t              sts,
	input  logic                        cfg_write,
	input  logic [1:0]                  cfg_index,
	input  logic [bffa_pkg::SEC_W-1:0]  cfg_data,
	input  logic [bffa_pkg::ADDR_W-1:0] request_bytes,
	input  logic [bffa_pkg::ADDR_W-1:0] release_address,
	output logic                        done,
	output logic [bffa_pkg::ADDR_W-1:0] granted_address,
	output logic [1:0]                  status
);
	import bffa_pkg::*;

	logic [SEC_W-1:0]  sector_q;
	logic [10:0]       total_q;
	logic [10:0]       reserved_q;
	logic [SEC_W-1:0]  s_eff;
	logic [CNT_W-1:0]  count;

	logic [ADDR_W-1:0] bytes_q;
	logic [ADDR_W-1:0] rel_q;
	logic [ADDR_W-1:0] first_q;
	logic [SIZE_W-1:0] size_q;
	logic [SIZE_W-1:0] size_rd_q;
	logic              first_in;

	logic [BLK_W-1:0]  clr_q;
	logic [IDX_W-1:0]  a_q;
	logic [IDX_W-1:0]  i_s1;
	logic              v_s1;
	logic              used_s1;
	logic [CNT_W-1:0]  len_q;
	logic [BLK_W-1:0]  start_q;
	logic [ADDR_W-1:0] base_q;
	logic [CNT_W-1:0]  j_q;
	logic [CNT_W-1:0]  end_q;

	logic              done_q;
	logic [1:0]        status_q;
	logic [ADDR_W-1:0] granted_q;

	logic              used_mem [MAX_BLOCKS];
	logic [SIZE_W-1:0] size_mem [MAX_BLOCKS];

	logic              div_done;
	logic [DIV_W-1:0]  quo;
	logic [DIV_W-1:0]  dividend;

	logic [PRD_W-1:0]  prod;
	logic              over;
	logic              issue;
	logic              blk_free;
	logic [BLK_W-1:0]  start_sel;
	logic [DIV_W-1:0]  len_inc;
	logic [DIV_W:0]    run_end;

	logic              u_we;
	logic [BLK_W-1:0]  u_wa;
	logic              u_wd;
	logic              s_we;
	logic [BLK_W-1:0]  s_wa;
	logic [SIZE_W-1:0] s_wd;

	assign s_eff    = (sector_q == '0) ? SEC_W'(1) : sector_q;
	assign count    = (32'(total_q) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
		: CNT_W'(total_q);
	assign first_in = 32'(first_q) < 32'(MAX_BLOCKS);

	always_comb begin
		case (cmd.div_sel)
			DSEL_NEED:  dividend = DIV_W'(HEADER_BYTES) + DIV_W'(bytes_q)
				+ DIV_W'(s_eff) - DIV_W'(1);
			DSEL_FIRST: dividend = DIV_W'(rel_q) - DIV_W'(HEADER_BYTES);
			default:    dividend = DIV_W'(HEADER_BYTES) + DIV_W'(size_q)
				+ DIV_W'(s_eff) - DIV_W'(1);
		endcase
	end

	bffa_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.div_go),
		.dividend (dividend),
		.divisor  (s_eff),
		.done     (div_done),
		.quotient (quo)
	);

	assign prod      = PRD_W'(i_s1) * PRD_W'(s_eff) + PRD_W'(HEADER_BYTES);
	assign over      = prod > PRD_W'(ADDR_MAX);
	assign issue     = cmd.scan_run && (a_q < IDX_W'(count));
	assign blk_free  = v_s1 && !used_s1;
	assign start_sel = (len_q == '0) ? i_s1[BLK_W-1:0] : start_q;
	assign len_inc   = DIV_W'(len_q) + DIV_W'(1);
	assign run_end   = (DIV_W + 1)'(first_q) + (DIV_W + 1)'(quo);

	always_comb begin
		sts           = '0;
		sts.clr_last  = clr_q == {BLK_W{1'b1}};
		sts.div_done  = div_done;
		sts.hit       = cmd.scan_run && blk_free && !((len_q == '0) && over)
			&& (len_inc >= quo);
		sts.fail      = cmd.scan_run && ((blk_free && (len_q == '0) && over)
			|| (!v_s1 && (a_q >= IDX_W'(count))));
		sts.mark_last = (j_q + CNT_W'(1)) == end_q;
		sts.free_more = j_q < end_q;
		sts.rel_zero  = release_address == '0;
		sts.rel_small = release_address < ADDR_W'(HEADER_BYTES);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sector_q   <= SEC_W'(512);
			total_q    <= 11'd1024;
			reserved_q <= 11'd1;
			clr_q      <= '0;
			v_s1       <= 1'b0;
			done_q     <= 1'b0;
			status_q   <= ST_OK;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					REG_SECTOR:   sector_q   <= cfg_data;
					REG_TOTAL:    total_q    <= cfg_data[10:0];
					REG_RESERVED: reserved_q <= cfg_data[10:0];
					default: ;
				endcase
			end
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			v_s1   <= issue;
			done_q <= cmd.fire;
			if (cmd.fire) begin
				status_q <= cmd.code;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			bytes_q <= request_bytes;
			rel_q   <= release_address;
		end
		if (cmd.fire) begin
			granted_q <= cmd.grant ? base_q : '0;
		end
		if (cmd.first_load) begin
			first_q <= quo[ADDR_W-1:0];
		end
		if (cmd.size_load) begin
			size_q <= first_in ? size_rd_q : '0;
		end
		if (cmd.scan_init) begin
			a_q   <= IDX_W'(reserved_q);
			len_q <= '0;
		end else if (cmd.scan_run) begin
			if (issue) begin
				a_q <= a_q + 1'b1;
			end
			i_s1 <= a_q;
			if (blk_free) begin
				len_q <= len_q + 1'b1;
				if (len_q == '0) begin
					start_q <= i_s1[BLK_W-1:0];
					base_q  <= prod[ADDR_W-1:0];
				end
			end else if (v_s1) begin
				len_q <= '0;
			end
			if (sts.hit) begin
				j_q   <= CNT_W'(start_sel);
				end_q <= CNT_W'(start_sel) + quo[CNT_W-1:0];
			end
		end
		if (cmd.free_set) begin
			if (32'(first_q) >= 32'(count)) begin
				j_q   <= '0;
				end_q <= '0;
			end else begin
				j_q   <= first_q[CNT_W-1:0];
				end_q <= (run_end > (DIV_W + 1)'(count)) ? count : run_end[CNT_W-1:0];
			end
		end
		if (cmd.mark_run || cmd.free_run) begin
			j_q <= j_q + 1'b1;
		end
	end

	always_comb begin
		u_we = 1'b0;
		u_wa = j_q[BLK_W-1:0];
		u_wd = 1'b0;
		s_we = 1'b0;
		s_wa = start_q;
		s_wd = '0;
		if (cmd.clr_step) begin
			u_we = 1'b1;
			u_wa = clr_q;
			s_we = 1'b1;
			s_wa = clr_q;
		end
		if (cmd.mark_run) begin
			u_we = 1'b1;
			u_wd = 1'b1;
			if (sts.mark_last) begin
				s_we = 1'b1;
				s_wd = SIZE_W'(bytes_q);
			end
		end
		if (cmd.free_run) begin
			u_we = 1'b1;
		end
		if (cmd.free_fin && first_in) begin
			s_we = 1'b1;
			s_wa = first_q[BLK_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (u_we) begin
			used_mem[u_wa] <= u_wd;
		end
		used_s1 <= used_mem[a_q[BLK_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (s_we) begin
			size_mem[s_wa] <= s_wd;
		end
		size_rd_q <= size_mem[first_q[BLK_W-1:0]];
	end

	assign done            = done_q;
	assign status          = status_q;
	assign granted_address = granted_q;
endmodule

### hw/rtl/bffa_controller.sv
// Controller state machine that sequences clearing, allocate and free requests.
module bffa_controller (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           req_type,
	input  bffa_pkg::sts_t sts,
	output bffa_pkg::cmd_t cmd,
	output logic           busy
);
	import bffa_pkg::*;

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_AGO   = 4'd2;
	localparam logic [3:0] S_ADIV  = 4'd3;
	localparam logic [3:0] S_SINIT = 4'd4;
	localparam logic [3:0] S_SCAN  = 4'd5;
	localparam logic [3:0] S_MARK  = 4'd6;
	localparam logic [3:0] S_FGO   = 4'd7;
	localparam logic [3:0] S_FDIV  = 4'd8;
	localparam logic [3:0] S_FRD   = 4'd9;
	localparam logic [3:0] S_FRDW  = 4'd10;
	localparam logic [3:0] S_NGO   = 4'd11;
	localparam logic [3:0] S_NDIV  = 4'd12;
	localparam logic [3:0] S_FSET  = 4'd13;
	localparam logic [3:0] S_FREE  = 4'd14;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.load_req = 1'b1;
					if (!req_type) begin
						state_d = S_AGO;
					end else if (sts.rel_zero) begin
						cmd.fire = 1'b1;
						cmd.code = ST_NULL;
					end else if (sts.rel_small) begin
						cmd.fire = 1'b1;
						cmd.code = ST_OK;
					end else begin
						state_d = S_FGO;
					end
				end
			end
			S_AGO: begin
				cmd.div_go  = 1'b1;
				cmd.div_sel = DSEL_NEED;
				state_d     = S_ADIV;
			end
			S_ADIV: begin
				cmd.div_sel = DSEL_NEED;
				if (sts.div_done) state_d = S_SINIT;
			end
			S_SINIT: begin
				cmd.div_sel   = DSEL_NEED;
				cmd.scan_init = 1'b1;
				state_d       = S_SCAN;
			end
			S_SCAN: begin
				cmd.div_sel  = DSEL_NEED;
				cmd.scan_run = 1'b1;
				if (sts.hit) begin
					state_d = S_MARK;
				end else if (sts.fail) begin
					cmd.fire = 1'b1;
					cmd.code = ST_NOSPACE;
					state_d  = S_IDLE;
				end
			end
			S_MARK: begin
				cmd.mark_run = 1'b1;
				if (sts.mark_last) begin
					cmd.fire  = 1'b1;
					cmd.grant = 1'b1;
					cmd.code  = ST_OK;
					state_d   = S_IDLE;
				end
			end
			S_FGO: begin
				cmd.div_go  = 1'b1;
				cmd.div_sel = DSEL_FIRST;
				state_d     = S_FDIV;
			end
			S_FDIV: begin
				cmd.div_sel = DSEL_FIRST;
				if (sts.div_done) begin
					cmd.first_load = 1'b1;
					state_d        = S_FRD;
				end
			end
			S_FRD: begin
				state_d = S_FRDW;
			end
			S_FRDW: begin
				cmd.size_load = 1'b1;
				state_d       = S_NGO;
			end
			S_NGO: begin
				cmd.div_go  = 1'b1;
				cmd.div_sel = DSEL_RUN;
				state_d     = S_NDIV;
			end
			S_NDIV: begin
				cmd.div_sel = DSEL_RUN;
				if (sts.div_done) state_d = S_FSET;
			end
			S_FSET: begin
				cmd.div_sel  = DSEL_RUN;
				cmd.free_set = 1'b1;
				state_d      = S_FREE;
			end
			S_FREE: begin
				if (sts.free_more) begin
					cmd.free_run = 1'b1;
				end else begin
					cmd.free_fin = 1'b1;
					cmd.fire     = 1'b1;
					cmd.code     = ST_OK;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != S_IDLE;
endmodule

### hw/rtl/bitmap_first_fit_block_allocator_core.sv
// Top level of the bitmap first-fit block allocator.
// After reset the block sweeps both stores, with busy high, before taking a request.
// An allocate divides, scans the bitmap, then marks the granted blocks.
// A free divides twice, reads the stored size and clears its blocks; a null or header-range free is answered from idle.
// The scan reads one bitmap bit per cycle from one memory port.
// One request is in flight at a time, and the result strobe done lasts one cycle.
module bitmap_first_fit_block_allocator_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        req_type,
	input  logic [bffa_pkg::ADDR_W-1:0] request_bytes,
	input  logic [bffa_pkg::ADDR_W-1:0] release_address,
	output logic                        done,
	output logic [bffa_pkg::ADDR_W-1:0] granted_address,
	output logic [1:0]                  status,
	input  logic                        cfg_write,
	input  logic [1:0]                  cfg_index,
	input  logic [bffa_pkg::SEC_W-1:0]  cfg_data
);
	import bffa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bffa_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	bffa_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.request_bytes   (request_bytes),
		.release_address (release_address),
		.done            (done),
		.granted_address (granted_address),
		.status          (status)
	);
endmodule

### hw/rtl/bffa_checker.sv
// Port-level checker for the block allocator and its bind to the top level.
module bffa_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic [bffa_pkg::ADDR_W-1:0] granted_address,
	input logic [1:0]                  status
);
	import bffa_pkg::*;

	a_done_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(start && !busy) || $past(busy)))
		else $error("Result strobe without a request in progress.");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("Result delivered while the block is still busy.");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> granted_address == '0)
		else $error("Nonzero address with a failing status.");

	a_grant_above_header: assert property (@(posedge clk) disable iff (!arst_n)
		(done && granted_address != '0) |-> (status == ST_OK
			&& granted_address >= ADDR_W'(HEADER_BYTES)))
		else $error("Granted address below the header size.");
endmodule

bind bitmap_first_fit_block_allocator_core bffa_checker u_bffa_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.done            (done),
	.granted_address (granted_address),
	.status          (status)
);
